### rtl/core/aps_pkg.sv
package aps_pkg;

    // Microprogram counter width: the program has fewer than 32 words.
    localparam int PC_W = 5;

    typedef logic [PC_W-1:0] t_pc;

    // Datapath micro-operations, one per control word.
    typedef enum logic [3:0] {
        U_NOP,
        U_MUL_RATE,
        U_MUL_SPEED,
        U_MUL_DECAY,
        U_MUL_DIFF,
        U_UPD,
        U_ADD_FRAME,
        U_SUB_WEIGHT,
        U_WRAP,
        U_COMMIT_FRAME,
        U_CHECK_END,
        U_DIFF,
        U_ONCE_TEST,
        U_PART_SPLIT,
        U_PART_JOIN,
        U_CLAMP
    } t_uop;

    // Sequencing field of a control word.
    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_GOTO_IF,
        J_END,
        J_END_IF
    } t_jump;

    typedef struct packed {
        t_uop  op;
        t_jump jmp;
        t_pc   target;
    } t_uword;

    // Start command from the top level to the sequencer.
    typedef struct packed {
        logic       start;
        logic       skip;
        logic [3:0] mode;
    } t_seq_cmd;

    // Control from the sequencer to the datapath.
    typedef struct packed {
        t_uop op;
        logic fin;
    } t_seq_ctl;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_POST
    } t_state;

    // Update modes.
    localparam logic [3:0] MODE_IDLE         = 4'd0;
    localparam logic [3:0] MODE_LEGACY_LOOP  = 4'd1;
    localparam logic [3:0] MODE_LEGACY_ONCE  = 4'd2;
    localparam logic [3:0] MODE_LEGACY_MORPH = 4'd3;
    localparam logic [3:0] MODE_DIRECT_LOOP  = 4'd4;
    localparam logic [3:0] MODE_DIRECT_PART  = 4'd5;
    localparam logic [3:0] MODE_DIRECT_ONCE  = 4'd6;
    localparam logic [3:0] MODE_DIRECT_MORPH = 4'd7;
    localparam logic [3:0] MODE_TAPER_MORPH  = 4'd8;

    // Pose effects.
    localparam logic [2:0] EFF_NONE            = 3'd0;
    localparam logic [2:0] EFF_LEGACY_SAMPLE   = 3'd1;
    localparam logic [2:0] EFF_LEGACY_BLEND    = 3'd2;
    localparam logic [2:0] EFF_DIRECT_SAMPLE   = 3'd3;
    localparam logic [2:0] EFF_DIRECT_TERMINAL = 3'd4;
    localparam logic [2:0] EFF_LINEAR_BLEND    = 3'd5;
    localparam logic [2:0] EFF_TAPER_BLEND     = 3'd6;

    // Configuration register indexes.
    localparam logic [2:0] CFG_LEGACY_SCALE = 3'd0;
    localparam logic [2:0] CFG_DIRECT_SCALE = 3'd1;
    localparam logic [2:0] CFG_TAPER_SCALE  = 3'd2;
    localparam logic [2:0] CFG_ZERO_LEVEL   = 3'd3;
    localparam logic [2:0] CFG_TAPER_ZERO   = 3'd4;

    // Animation kind thresholds for the mode that follows a morph.
    localparam logic [7:0] KIND_LOOP_LIMIT = 8'd2;
    localparam logic [7:0] KIND_PART_LIMIT = 8'd4;

    localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

endpackage

### rtl/core/aps_in_if.sv
interface aps_in_if;

    logic               valid;
    logic               ready;
    logic               operation;
    logic signed [31:0] tick_rate;
    logic signed [31:0] load_frame;
    logic signed [31:0] load_weight;
    logic        [3:0]  load_mode;
    logic signed [31:0] speed;
    logic signed [31:0] decay_rate;
    logic signed [31:0] first_frame;
    logic signed [31:0] last_frame;
    logic signed [31:0] length;
    logic        [7:0]  anim_kind;

    modport source (
        output valid, operation, tick_rate, load_frame, load_weight, load_mode,
               speed, decay_rate, first_frame, last_frame, length, anim_kind,
        input  ready
    );

    modport sink (
        input  valid, operation, tick_rate, load_frame, load_weight, load_mode,
               speed, decay_rate, first_frame, last_frame, length, anim_kind,
        output ready
    );

endinterface

### rtl/core/aps_out_if.sv
interface aps_out_if;

    logic               valid;
    logic               ready;
    logic               supported;
    logic        [2:0]  pose_effect;
    logic               complete;
    logic               wrote_frame;
    logic               wrote_weight;
    logic               wrote_mode;
    logic signed [31:0] frame_out;
    logic signed [31:0] weight_out;
    logic signed [31:0] prior_weight;
    logic        [3:0]  mode_out;

    modport source (
        output valid, supported, pose_effect, complete, wrote_frame, wrote_weight,
               wrote_mode, frame_out, weight_out, prior_weight, mode_out,
        input  ready
    );

    modport sink (
        input  valid, supported, pose_effect, complete, wrote_frame, wrote_weight,
               wrote_mode, frame_out, weight_out, prior_weight, mode_out,
        output ready
    );

endinterface

### rtl/core/aps_seq.sv
module aps_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  aps_pkg::t_seq_cmd i_cmd,
    input  logic              i_cond,
    output aps_pkg::t_seq_ctl o_ctl
);

    // Program entry points.
    localparam aps_pkg::t_pc A_SKIP   = aps_pkg::t_pc'(0);
    localparam aps_pkg::t_pc A_LOOP   = aps_pkg::t_pc'(1);
    localparam aps_pkg::t_pc A_WRAP   = aps_pkg::t_pc'(5);
    localparam aps_pkg::t_pc A_COMMIT = aps_pkg::t_pc'(6);
    localparam aps_pkg::t_pc A_ONCE   = aps_pkg::t_pc'(7);
    localparam aps_pkg::t_pc A_PART   = aps_pkg::t_pc'(16);
    localparam aps_pkg::t_pc A_MORPH  = aps_pkg::t_pc'(22);

    aps_pkg::t_pc   r_pc;
    aps_pkg::t_pc   n_pc;
    logic           r_run;
    logic           n_run;
    logic           fin;
    aps_pkg::t_uword word;

    function automatic aps_pkg::t_uword uw(input aps_pkg::t_uop op,
                                           input aps_pkg::t_jump jmp,
                                           input aps_pkg::t_pc target);
        aps_pkg::t_uword w;
        w.op     = op;
        w.jmp    = jmp;
        w.target = target;
        return w;
    endfunction

    // Microprogram store: one control word per step.
    function automatic aps_pkg::t_uword rom(input aps_pkg::t_pc pc);
        aps_pkg::t_uword w;
        unique case (pc)
            // Idle or undefined mode, load, or a rate that is not positive.
            aps_pkg::t_pc'(0):  w = uw(aps_pkg::U_NOP,          aps_pkg::J_END,     A_SKIP);
            // Full loop.
            aps_pkg::t_pc'(1):  w = uw(aps_pkg::U_MUL_RATE,     aps_pkg::J_NEXT,    A_SKIP);
            aps_pkg::t_pc'(2):  w = uw(aps_pkg::U_UPD,          aps_pkg::J_NEXT,    A_SKIP);
            aps_pkg::t_pc'(3):  w = uw(aps_pkg::U_MUL_SPEED,    aps_pkg::J_NEXT,    A_SKIP);
            aps_pkg::t_pc'(4):  w = uw(aps_pkg::U_ADD_FRAME,    aps_pkg::J_NEXT,    A_SKIP);
            aps_pkg::t_pc'(5):  w = uw(aps_pkg::U_WRAP,         aps_pkg::J_NEXT,    A_SKIP);
            aps_pkg::t_pc'(6):  w = uw(aps_pkg::U_COMMIT_FRAME, aps_pkg::J_END,     A_SKIP);
            // Play once.
            aps_pkg::t_pc'(7):  w = uw(aps_pkg::U_CHECK_END,    aps_pkg::J_END_IF,  A_SKIP);
            aps_pkg::t_pc'(8):  w = uw(aps_pkg::U_MUL_RATE,     aps_pkg::J_NEXT,    A_SKIP);
            aps_pkg::t_pc'(9):  w = uw(aps_pkg::U_UPD,          aps_pkg::J_NEXT,    A_SKIP);
            aps_pkg::t_pc'(10): w = uw(aps_pkg::U_MUL_SPEED,    aps_pkg::J_NEXT,    A_SKIP);
            aps_pkg::t_pc'(11): w = uw(aps_pkg::U_ADD_FRAME,    aps_pkg::J_NEXT,    A_SKIP);
            aps_pkg::t_pc'(12): w = uw(aps_pkg::U_DIFF,         aps_pkg::J_NEXT,    A_SKIP);
            aps_pkg::t_pc'(13): w = uw(aps_pkg::U_MUL_DIFF,     aps_pkg::J_NEXT,    A_SKIP);
            aps_pkg::t_pc'(14): w = uw(aps_pkg::U_ONCE_TEST,    aps_pkg::J_GOTO_IF, A_COMMIT);
            aps_pkg::t_pc'(15): w = uw(aps_pkg::U_NOP,          aps_pkg::J_GOTO,    A_WRAP);
            // Partial loop.
            aps_pkg::t_pc'(16): w = uw(aps_pkg::U_MUL_RATE,     aps_pkg::J_NEXT,    A_SKIP);
            aps_pkg::t_pc'(17): w = uw(aps_pkg::U_UPD,          aps_pkg::J_NEXT,    A_SKIP);
            aps_pkg::t_pc'(18): w = uw(aps_pkg::U_MUL_SPEED,    aps_pkg::J_NEXT,    A_SKIP);
            aps_pkg::t_pc'(19): w = uw(aps_pkg::U_ADD_FRAME,    aps_pkg::J_NEXT,    A_SKIP);
            aps_pkg::t_pc'(20): w = uw(aps_pkg::U_PART_SPLIT,   aps_pkg::J_NEXT,    A_SKIP);
            aps_pkg::t_pc'(21): w = uw(aps_pkg::U_PART_JOIN,    aps_pkg::J_GOTO,    A_COMMIT);
            // Morph weight decay.
            aps_pkg::t_pc'(22): w = uw(aps_pkg::U_MUL_RATE,     aps_pkg::J_NEXT,    A_SKIP);
            aps_pkg::t_pc'(23): w = uw(aps_pkg::U_UPD,          aps_pkg::J_NEXT,    A_SKIP);
            aps_pkg::t_pc'(24): w = uw(aps_pkg::U_MUL_DECAY,    aps_pkg::J_NEXT,    A_SKIP);
            aps_pkg::t_pc'(25): w = uw(aps_pkg::U_SUB_WEIGHT,   aps_pkg::J_NEXT,    A_SKIP);
            aps_pkg::t_pc'(26): w = uw(aps_pkg::U_CLAMP,        aps_pkg::J_END,     A_SKIP);
            default:            w = uw(aps_pkg::U_NOP,          aps_pkg::J_END,     A_SKIP);
        endcase
        return w;
    endfunction

    // Dispatch on the update mode.
    function automatic aps_pkg::t_pc entry(input logic [3:0] mode);
        aps_pkg::t_pc pc;
        unique case (mode)
            aps_pkg::MODE_LEGACY_LOOP,
            aps_pkg::MODE_DIRECT_LOOP:  pc = A_LOOP;
            aps_pkg::MODE_LEGACY_ONCE,
            aps_pkg::MODE_DIRECT_ONCE:  pc = A_ONCE;
            aps_pkg::MODE_DIRECT_PART:  pc = A_PART;
            aps_pkg::MODE_LEGACY_MORPH,
            aps_pkg::MODE_DIRECT_MORPH,
            aps_pkg::MODE_TAPER_MORPH:  pc = A_MORPH;
            default:                    pc = A_SKIP;
        endcase
        return pc;
    endfunction

    // Next step and end of program.
    always_comb begin
        word  = rom(r_pc);
        n_pc  = r_pc;
        n_run = r_run;
        fin   = 1'b0;
        if (r_run) begin
            unique case (word.jmp)
                aps_pkg::J_NEXT:    n_pc = r_pc + aps_pkg::t_pc'(1);
                aps_pkg::J_GOTO:    n_pc = word.target;
                aps_pkg::J_GOTO_IF: n_pc = i_cond ? word.target : r_pc + aps_pkg::t_pc'(1);
                aps_pkg::J_END:     fin  = 1'b1;
                aps_pkg::J_END_IF: begin
                    if (i_cond) begin
                        fin = 1'b1;
                    end else begin
                        n_pc = r_pc + aps_pkg::t_pc'(1);
                    end
                end
                default:            fin  = 1'b1;
            endcase
            if (fin) begin
                n_run = 1'b0;
            end
        end
        if (i_cmd.start) begin
            n_pc  = i_cmd.skip ? A_SKIP : entry(i_cmd.mode);
            n_run = 1'b1;
        end
    end

    // Step counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= A_SKIP;
            r_run <= 1'b0;
        end else begin
            r_pc  <= n_pc;
            r_run <= n_run;
        end
    end

    assign o_ctl.op  = r_run ? word.op : aps_pkg::U_NOP;
    assign o_ctl.fin = fin;

endmodule

### rtl/core/animation_playback_stepper.sv
// Animation playback stepper. A load word replaces the animation settings and
// returns the loaded state with supported low; a tick word advances the frame
// or decays the morph weight in the current update mode, all in signed fixed
// point with FRAC_BITS fraction bits and saturating arithmetic. One word is
// processed at a time: a load, a tick with a rate that is not positive, or a
// tick in an idle mode runs only the empty step of the microprogram; a
// play-once step stops at its first step when the end frame was already
// reached, and pins the frame to the end when the step runs past it. The
// microprogram runs every product through the one shared 32 by 32 multiplier.
// A finished result waits in the output register without blocking the next
// word; the result after it waits for that register to be taken.
module animation_playback_stepper #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    aps_in_if.sink      i_req,
    aps_out_if.source   o_rsp
);

    localparam logic [30:0] SCALE_ONE = 31'd1 << FRAC_BITS;

    aps_pkg::t_state   r_state;
    aps_pkg::t_state   n_state;
    aps_pkg::t_seq_cmd seq_cmd;
    aps_pkg::t_seq_ctl seq_ctl;
    logic              seq_cond;
    logic              accept;
    logic              out_load;
    logic              rate_ok;

    // Configuration.
    logic        [30:0] r_legacy_scale;
    logic        [30:0] r_direct_scale;
    logic        [30:0] r_taper_scale;
    logic signed [31:0] r_zero;
    logic signed [31:0] r_taper_zero;

    // Animation state.
    logic signed [31:0] r_frame;
    logic signed [31:0] r_weight;
    logic        [3:0]  r_mode;
    logic signed [31:0] r_speed;
    logic signed [31:0] r_decay;
    logic signed [31:0] r_first;
    logic signed [31:0] r_last;
    logic signed [31:0] r_length;
    logic        [7:0]  r_kind;

    // Working registers.
    logic signed [31:0] r_rate;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_upd;
    logic signed [31:0] r_f;
    logic signed [31:0] r_d;
    logic               r_join;

    // Result of the word in progress.
    logic               r_supported;
    logic        [2:0]  r_effect;
    logic               r_complete;
    logic               r_wf;
    logic               r_ww;
    logic               r_wm;
    logic signed [31:0] r_prior;

    // Output register.
    logic               r_out_valid;
    logic               r_out_supported;
    logic        [2:0]  r_out_effect;
    logic               r_out_complete;
    logic               r_out_wf;
    logic               r_out_ww;
    logic               r_out_wm;
    logic signed [31:0] r_out_frame;
    logic signed [31:0] r_out_weight;
    logic signed [31:0] r_out_prior;
    logic        [3:0]  r_out_mode;

    // Datapath signals.
    logic        [30:0] scale_sel;
    logic signed [31:0] mul_a;
    logic signed [31:0] mul_b;
    logic signed [63:0] mul_p;
    logic signed [63:0] prod_sh;
    logic               prod_fits;
    logic signed [31:0] prod_q;
    logic signed [63:0] z_lim;
    logic               once_hit;
    logic               end_hit;
    logic signed [31:0] morph_floor;
    logic        [3:0]  morph_next;

    function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        if (s[32] != s[31]) begin
            return s[32] ? aps_pkg::Q_MIN : aps_pkg::Q_MAX;
        end
        return s[31:0];
    endfunction

    function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                   input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) - 33'(b);
        if (s[32] != s[31]) begin
            return s[32] ? aps_pkg::Q_MIN : aps_pkg::Q_MAX;
        end
        return s[31:0];
    endfunction

    function automatic logic [2:0] mode_effect(input logic [3:0] mode);
        logic [2:0] e;
        unique case (mode)
            aps_pkg::MODE_LEGACY_LOOP,
            aps_pkg::MODE_LEGACY_ONCE:  e = aps_pkg::EFF_LEGACY_SAMPLE;
            aps_pkg::MODE_LEGACY_MORPH: e = aps_pkg::EFF_LEGACY_BLEND;
            aps_pkg::MODE_DIRECT_LOOP,
            aps_pkg::MODE_DIRECT_PART,
            aps_pkg::MODE_DIRECT_ONCE:  e = aps_pkg::EFF_DIRECT_SAMPLE;
            aps_pkg::MODE_DIRECT_MORPH: e = aps_pkg::EFF_LINEAR_BLEND;
            aps_pkg::MODE_TAPER_MORPH:  e = aps_pkg::EFF_TAPER_BLEND;
            default:                    e = aps_pkg::EFF_NONE;
        endcase
        return e;
    endfunction

    function automatic logic is_morph(input logic [3:0] mode);
        return (mode == aps_pkg::MODE_LEGACY_MORPH) || (mode == aps_pkg::MODE_DIRECT_MORPH)
            || (mode == aps_pkg::MODE_TAPER_MORPH);
    endfunction

    // Sequencer.
    assign accept        = i_req.valid && i_req.ready;
    assign rate_ok       = i_req.tick_rate > 32'sd0;
    assign seq_cmd.start = accept;
    assign seq_cmd.skip  = i_req.operation || !rate_ok;
    assign seq_cmd.mode  = r_mode;

    aps_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (seq_cmd),
        .i_cond  (seq_cond),
        .o_ctl   (seq_ctl)
    );

    // Control state and handshakes.
    always_comb begin
        n_state     = r_state;
        out_load    = 1'b0;
        i_req.ready = 1'b0;
        unique case (r_state)
            aps_pkg::S_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_state = aps_pkg::S_RUN;
                end
            end
            aps_pkg::S_RUN: begin
                if (seq_ctl.fin) begin
                    n_state = aps_pkg::S_POST;
                end
            end
            aps_pkg::S_POST: begin
                out_load = !r_out_valid || o_rsp.ready;
                if (out_load) begin
                    n_state = aps_pkg::S_IDLE;
                end
            end
            default: n_state = aps_pkg::S_IDLE;
        endcase
    end

    // Scale for the current mode group.
    always_comb begin
        unique case (r_mode)
            aps_pkg::MODE_LEGACY_LOOP,
            aps_pkg::MODE_LEGACY_ONCE,
            aps_pkg::MODE_LEGACY_MORPH: scale_sel = r_legacy_scale;
            aps_pkg::MODE_DIRECT_LOOP,
            aps_pkg::MODE_DIRECT_PART,
            aps_pkg::MODE_DIRECT_ONCE,
            aps_pkg::MODE_DIRECT_MORPH: scale_sel = r_direct_scale;
            default:                    scale_sel = r_taper_scale;
        endcase
    end

    // Shared multiplier operand selection.
    always_comb begin
        unique case (seq_ctl.op)
            aps_pkg::U_MUL_RATE: begin
                mul_a = r_rate;
                mul_b = {1'b0, scale_sel};
            end
            aps_pkg::U_MUL_SPEED: begin
                mul_a = r_speed;
                mul_b = r_upd;
            end
            aps_pkg::U_MUL_DECAY: begin
                mul_a = r_decay;
                mul_b = r_upd;
            end
            default: begin
                mul_a = r_d;
                mul_b = r_speed;
            end
        endcase
    end

    assign mul_p = 64'(mul_a) * 64'(mul_b);

    // Product rescale: an arithmetic shift rounds toward minus infinity.
    assign prod_sh   = r_prod >>> FRAC_BITS;
    assign prod_fits = (&prod_sh[63:31]) || !(|prod_sh[63:31]);
    assign prod_q    = prod_fits ? prod_sh[31:0]
                                 : (prod_sh[63] ? aps_pkg::Q_MIN : aps_pkg::Q_MAX);

    // End tests: exact product of overshoot and speed against the scaled floor.
    assign z_lim    = 64'(r_zero) <<< FRAC_BITS;
    assign once_hit = r_prod > z_lim;
    assign end_hit  = r_frame == r_last;

    always_comb begin
        unique case (seq_ctl.op)
            aps_pkg::U_CHECK_END: seq_cond = end_hit;
            aps_pkg::U_ONCE_TEST: seq_cond = once_hit;
            default:              seq_cond = 1'b0;
        endcase
    end

    // Morph floor and the mode that follows a finished morph.
    assign morph_floor = (r_mode == aps_pkg::MODE_TAPER_MORPH) ? r_taper_zero : r_zero;

    always_comb begin
        if (r_mode == aps_pkg::MODE_LEGACY_MORPH) begin
            morph_next = (r_kind < aps_pkg::KIND_LOOP_LIMIT) ? aps_pkg::MODE_LEGACY_LOOP
                                                             : aps_pkg::MODE_LEGACY_ONCE;
        end else if (r_kind < aps_pkg::KIND_LOOP_LIMIT) begin
            morph_next = aps_pkg::MODE_DIRECT_LOOP;
        end else if (r_kind < aps_pkg::KIND_PART_LIMIT) begin
            morph_next = aps_pkg::MODE_DIRECT_ONCE;
        end else begin
            morph_next = aps_pkg::MODE_DIRECT_PART;
        end
    end

    // Control, configuration, animation state and result flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= aps_pkg::S_IDLE;
            r_out_valid    <= 1'b0;
            r_legacy_scale <= SCALE_ONE;
            r_direct_scale <= SCALE_ONE;
            r_taper_scale  <= SCALE_ONE;
            r_zero         <= '0;
            r_taper_zero   <= '0;
            r_frame        <= '0;
            r_weight       <= '0;
            r_mode         <= aps_pkg::MODE_IDLE;
            r_speed        <= '0;
            r_decay        <= '0;
            r_first        <= '0;
            r_last         <= '0;
            r_length       <= '0;
            r_kind         <= '0;
            r_supported    <= 1'b0;
            r_effect       <= aps_pkg::EFF_NONE;
            r_complete     <= 1'b0;
            r_wf           <= 1'b0;
            r_ww           <= 1'b0;
            r_wm           <= 1'b0;
            r_prior        <= '0;
        end else begin
            r_state <= n_state;

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    aps_pkg::CFG_LEGACY_SCALE: r_legacy_scale <= i_cfg_wdata[30:0];
                    aps_pkg::CFG_DIRECT_SCALE: r_direct_scale <= i_cfg_wdata[30:0];
                    aps_pkg::CFG_TAPER_SCALE:  r_taper_scale  <= i_cfg_wdata[30:0];
                    aps_pkg::CFG_ZERO_LEVEL:   r_zero         <= i_cfg_wdata;
                    aps_pkg::CFG_TAPER_ZERO:   r_taper_zero   <= i_cfg_wdata;
                    default: ;
                endcase
            end

            // A new word: load the settings or prime the result of a tick.
            if (accept) begin
                r_complete <= 1'b0;
                r_wf       <= 1'b0;
                r_ww       <= 1'b0;
                r_wm       <= 1'b0;
                if (i_req.operation) begin
                    r_frame     <= i_req.load_frame;
                    r_weight    <= i_req.load_weight;
                    r_mode      <= i_req.load_mode;
                    r_speed     <= i_req.speed;
                    r_decay     <= i_req.decay_rate;
                    r_first     <= i_req.first_frame;
                    r_last      <= i_req.last_frame;
                    r_length    <= i_req.length;
                    r_kind      <= i_req.anim_kind;
                    r_supported <= 1'b0;
                    r_effect    <= aps_pkg::EFF_NONE;
                    r_prior     <= '0;
                end else begin
                    r_supported <= rate_ok;
                    r_effect    <= rate_ok ? mode_effect(r_mode) : aps_pkg::EFF_NONE;
                    r_prior     <= (rate_ok && is_morph(r_mode)) ? r_weight : 32'sd0;
                end
            end

            // Steps that write the animation state or the flags.
            unique case (seq_ctl.op)
                aps_pkg::U_COMMIT_FRAME: begin
                    r_frame <= r_f;
                    r_wf    <= 1'b1;
                end
                aps_pkg::U_CHECK_END: begin
                    if (end_hit) begin
                        r_complete <= 1'b1;
                        if (r_mode == aps_pkg::MODE_DIRECT_ONCE) begin
                            r_effect <= aps_pkg::EFF_DIRECT_TERMINAL;
                        end
                    end
                end
                aps_pkg::U_CLAMP: begin
                    r_ww <= 1'b1;
                    if (r_f <= morph_floor) begin
                        r_weight <= morph_floor;
                        r_mode   <= morph_next;
                        r_wm     <= 1'b1;
                    end else begin
                        r_weight <= r_f;
                    end
                end
                default: ;
            endcase
        end
    end

    // Working registers of the datapath.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_rate <= i_req.tick_rate;
        end
        unique case (seq_ctl.op)
            aps_pkg::U_MUL_RATE,
            aps_pkg::U_MUL_SPEED,
            aps_pkg::U_MUL_DECAY,
            aps_pkg::U_MUL_DIFF:   r_prod <= mul_p;
            aps_pkg::U_UPD:        r_upd  <= prod_q;
            aps_pkg::U_ADD_FRAME:  r_f    <= sat_add(r_frame, prod_q);
            aps_pkg::U_SUB_WEIGHT: r_f    <= sat_sub(r_weight, prod_q);
            aps_pkg::U_DIFF:       r_d    <= sat_sub(r_f, r_last);
            aps_pkg::U_WRAP: begin
                if (r_f < r_zero) begin
                    r_f <= sat_add(r_f, r_length);
                end else if (r_f >= r_length) begin
                    r_f <= sat_sub(r_f, r_length);
                end
            end
            aps_pkg::U_ONCE_TEST: begin
                if (once_hit) begin
                    r_f <= r_last;
                end
            end
            // Partial loop wrap: take off one bound, then add the other.
            aps_pkg::U_PART_SPLIT: begin
                if (r_f < r_first) begin
                    r_f    <= sat_sub(r_f, r_first);
                    r_d    <= r_last;
                    r_join <= 1'b1;
                end else if (r_f >= r_last) begin
                    r_f    <= sat_sub(r_f, r_last);
                    r_d    <= r_first;
                    r_join <= 1'b1;
                end else begin
                    r_join <= 1'b0;
                end
            end
            aps_pkg::U_PART_JOIN: begin
                if (r_join) begin
                    r_f <= sat_add(r_f, r_d);
                end
            end
            default: ;
        endcase
    end

    // Output register payload.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_supported <= r_supported;
            r_out_effect    <= r_effect;
            r_out_complete  <= r_complete;
            r_out_wf        <= r_wf;
            r_out_ww        <= r_ww;
            r_out_wm        <= r_wm;
            r_out_frame     <= r_frame;
            r_out_weight    <= r_weight;
            r_out_prior     <= r_prior;
            r_out_mode      <= r_mode;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.supported    = r_out_supported;
    assign o_rsp.pose_effect  = r_out_effect;
    assign o_rsp.complete     = r_out_complete;
    assign o_rsp.wrote_frame  = r_out_wf;
    assign o_rsp.wrote_weight = r_out_ww;
    assign o_rsp.wrote_mode   = r_out_wm;
    assign o_rsp.frame_out    = r_out_frame;
    assign o_rsp.weight_out   = r_out_weight;
    assign o_rsp.prior_weight = r_out_prior;
    assign o_rsp.mode_out     = r_out_mode;

`ifndef SYNTHESIS
    // The microprogram only finishes while a word is being worked on.
    a_fin_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        seq_ctl.fin |-> r_state == aps_pkg::S_RUN)
        else $error("sequencer finished outside the run state");

    // A new result appears only after the microprogram has finished.
    a_out_from_post: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state) == aps_pkg::S_POST)
        else $error("result word raised without a finished step");

    // A mode change only follows a finished morph, which also writes the weight.
    a_mode_with_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_wm) |-> r_out_ww)
        else $error("mode written without a weight write");

    // An unsupported word leaves every flag clear.
    a_unsupported_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_supported) |->
            (r_out_effect == aps_pkg::EFF_NONE) && !r_out_wf && !r_out_ww
            && !r_out_wm && !r_out_complete)
        else $error("unsupported word carries flags");

    // A completed play-once step never moves the frame.
    a_complete_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_complete) |-> !r_out_wf)
        else $error("completed animation also wrote the frame");
`endif

endmodule

### tb/aps_result_checker.sv
`timescale 1ns / 1ps

// Watches the configuration port and both word channels of the stepper. Every
// accepted request word is run through a local copy of the animation state to
// give the result word it must produce, and every accepted result word is
// compared with the oldest prediction still waiting.
module aps_result_checker
    import aps_pkg::*;
#(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_wdata,
    aps_in_if           i_req,
    aps_out_if          i_rsp,
    output int          o_mismatches,
    output int          o_pending,
    output int          o_checked
);

    typedef logic signed [31:0] q_t;

    typedef struct packed {
        logic       supported;
        logic [2:0] effect;
        logic       complete;
        logic       wrote_frame;
        logic       wrote_weight;
        logic       wrote_mode;
        q_t         frame;
        q_t         weight;
        q_t         prior;
        logic [3:0] mode;
    } step_result_t;

    // Register copies.
    logic [30:0] scale_legacy;
    logic [30:0] scale_direct;
    logic [30:0] scale_taper;
    q_t          floor_level;
    q_t          taper_floor;

    // Animation state as the block should hold it.
    q_t         cur_frame;
    q_t         cur_weight;
    logic [3:0] cur_mode;
    q_t         held_speed;
    q_t         held_decay;
    q_t         held_first;
    q_t         held_last;
    q_t         held_length;
    logic [7:0] held_kind;

    step_result_t result_q[$];
    step_result_t predicted;
    step_result_t oldest;
    int           errors = 0;
    int           compared = 0;

    // Saturating Q16.16 arithmetic.
    function automatic q_t sat_q(input longint v);
        if (v > longint'(Q_MAX)) return Q_MAX;
        if (v < longint'(Q_MIN)) return Q_MIN;
        return v[31:0];
    endfunction

    function automatic q_t add_q(input q_t a, input q_t b);
        return sat_q(longint'(a) + longint'(b));
    endfunction

    function automatic q_t sub_q(input q_t a, input q_t b);
        return sat_q(longint'(a) - longint'(b));
    endfunction

    // The arithmetic shift of the exact product rounds towards minus infinity.
    function automatic q_t mul_q(input q_t a, input q_t b);
        longint prod;
        prod = longint'(a) * longint'(b);
        return sat_q(prod >>> FRAC_BITS);
    endfunction

    // Full loop: one wrap by the animation length at most.
    function automatic q_t wrap_length(input q_t f);
        if (f < floor_level) return add_q(f, held_length);
        if (f >= held_length) return sub_q(f, held_length);
        return f;
    endfunction

    function automatic q_t loop_part(input q_t upd);
        q_t f;
        f = add_q(cur_frame, mul_q(held_speed, upd));
        if (f < held_first) return add_q(sub_q(f, held_first), held_last);
        if (f >= held_last) return add_q(sub_q(f, held_last), held_first);
        return f;
    endfunction

    // Play once: the overshoot past the end frame is weighed against the
    // floor at full product precision before the frame is pinned to the end.
    function automatic q_t play_once(input q_t upd);
        q_t     f;
        q_t     overshoot;
        longint prod;
        longint level;
        f         = add_q(cur_frame, mul_q(held_speed, upd));
        overshoot = sub_q(f, held_last);
        prod      = longint'(overshoot) * longint'(held_speed);
        level     = longint'(floor_level) * (longint'(1) <<< FRAC_BITS);
        if (prod > level) return held_last;
        return wrap_length(f);
    endfunction

    function automatic logic [3:0] direct_follow_on(input logic [7:0] kind);
        if (kind < KIND_LOOP_LIMIT) return MODE_DIRECT_LOOP;
        if (kind < KIND_PART_LIMIT) return MODE_DIRECT_ONCE;
        return MODE_DIRECT_PART;
    endfunction

    task automatic decay_weight(input q_t upd, input q_t floor_v, output logic done);
        q_t w;
        w          = sub_q(cur_weight, mul_q(held_decay, upd));
        done       = (w <= floor_v);
        cur_weight = done ? floor_v : w;
    endtask

    task automatic reset_animation();
        scale_legacy = 31'(1 << FRAC_BITS);
        scale_direct = 31'(1 << FRAC_BITS);
        scale_taper  = 31'(1 << FRAC_BITS);
        floor_level  = '0;
        taper_floor  = '0;
        cur_frame    = '0;
        cur_weight   = '0;
        cur_mode     = MODE_IDLE;
        held_speed   = '0;
        held_decay   = '0;
        held_first   = '0;
        held_last    = '0;
        held_length  = '0;
        held_kind    = '0;
    endtask

    // Applies one request word to the local state and gives its result word.
    task automatic advance_animation(output step_result_t r);
        q_t   upd_legacy;
        q_t   upd_direct;
        q_t   upd_taper;
        logic done;
        r = '0;
        if (i_req.operation) begin
            cur_frame   = i_req.load_frame;
            cur_weight  = i_req.load_weight;
            cur_mode    = i_req.load_mode;
            held_speed  = i_req.speed;
            held_decay  = i_req.decay_rate;
            held_first  = i_req.first_frame;
            held_last   = i_req.last_frame;
            held_length = i_req.length;
            held_kind   = i_req.anim_kind;
        end else if (i_req.tick_rate > 0) begin
            upd_legacy  = mul_q(i_req.tick_rate, $signed({1'b0, scale_legacy}));
            upd_direct  = mul_q(i_req.tick_rate, $signed({1'b0, scale_direct}));
            upd_taper   = mul_q(i_req.tick_rate, $signed({1'b0, scale_taper}));
            r.supported = 1'b1;
            case (cur_mode)
                MODE_LEGACY_LOOP: begin
                    cur_frame     = wrap_length(add_q(cur_frame, mul_q(held_speed, upd_legacy)));
                    r.effect      = EFF_LEGACY_SAMPLE;
                    r.wrote_frame = 1'b1;
                end
                MODE_LEGACY_ONCE: begin
                    r.effect = EFF_LEGACY_SAMPLE;
                    if (cur_frame == held_last) begin
                        r.complete = 1'b1;
                    end else begin
                        cur_frame     = play_once(upd_legacy);
                        r.wrote_frame = 1'b1;
                    end
                end
                MODE_LEGACY_MORPH: begin
                    r.prior        = cur_weight;
                    r.effect       = EFF_LEGACY_BLEND;
                    r.wrote_weight = 1'b1;
                    decay_weight(upd_legacy, floor_level, done);
                    if (done) begin
                        cur_mode    = (held_kind < KIND_LOOP_LIMIT) ? MODE_LEGACY_LOOP
                                                                    : MODE_LEGACY_ONCE;
                        r.wrote_mode = 1'b1;
                    end
                end
                MODE_DIRECT_LOOP: begin
                    cur_frame     = wrap_length(add_q(cur_frame, mul_q(held_speed, upd_direct)));
                    r.effect      = EFF_DIRECT_SAMPLE;
                    r.wrote_frame = 1'b1;
                end
                MODE_DIRECT_PART: begin
                    cur_frame     = loop_part(upd_direct);
                    r.effect      = EFF_DIRECT_SAMPLE;
                    r.wrote_frame = 1'b1;
                end
                MODE_DIRECT_ONCE: begin
                    if (cur_frame == held_last) begin
                        r.effect   = EFF_DIRECT_TERMINAL;
                        r.complete = 1'b1;
                    end else begin
                        cur_frame     = play_once(upd_direct);
                        r.effect      = EFF_DIRECT_SAMPLE;
                        r.wrote_frame = 1'b1;
                    end
                end
                MODE_DIRECT_MORPH: begin
                    r.prior        = cur_weight;
                    r.effect       = EFF_LINEAR_BLEND;
                    r.wrote_weight = 1'b1;
                    decay_weight(upd_direct, floor_level, done);
                    if (done) begin
                        cur_mode     = direct_follow_on(held_kind);
                        r.wrote_mode = 1'b1;
                    end
                end
                MODE_TAPER_MORPH: begin
                    r.prior        = cur_weight;
                    r.effect       = EFF_TAPER_BLEND;
                    r.wrote_weight = 1'b1;
                    decay_weight(upd_taper, taper_floor, done);
                    if (done) begin
                        cur_mode     = direct_follow_on(held_kind);
                        r.wrote_mode = 1'b1;
                    end
                end
                default: begin
                    // Idle and undefined modes only report support.
                end
            endcase
        end
        r.frame  = cur_frame;
        r.weight = cur_weight;
        r.mode   = cur_mode;
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
        end
    endtask

    // Result words are compared before the new request word is predicted, so
    // that a stray result can never be matched with a word accepted alongside.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reset_animation();
            result_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_LEGACY_SCALE: scale_legacy = i_cfg_wdata[30:0];
                    CFG_DIRECT_SCALE: scale_direct = i_cfg_wdata[30:0];
                    CFG_TAPER_SCALE:  scale_taper  = i_cfg_wdata[30:0];
                    CFG_ZERO_LEVEL:   floor_level  = i_cfg_wdata;
                    CFG_TAPER_ZERO:   taper_floor  = i_cfg_wdata;
                    default: begin
                        // Unused indexes leave every register alone.
                    end
                endcase
            end
            if (i_rsp.valid && i_rsp.ready) begin
                if (result_q.size() == 0) begin
                    errors++;
                    $display("%0t: result word with nothing expected, expected none, got frame %h",
                             $time, i_rsp.frame_out);
                end else begin
                    oldest = result_q.pop_front();
                    compared++;
                    check_field("supported", oldest.supported, i_rsp.supported);
                    check_field("pose_effect", oldest.effect, i_rsp.pose_effect);
                    check_field("complete", oldest.complete, i_rsp.complete);
                    check_field("wrote_frame", oldest.wrote_frame, i_rsp.wrote_frame);
                    check_field("wrote_weight", oldest.wrote_weight, i_rsp.wrote_weight);
                    check_field("wrote_mode", oldest.wrote_mode, i_rsp.wrote_mode);
                    check_field("frame_out", oldest.frame, i_rsp.frame_out);
                    check_field("weight_out", oldest.weight, i_rsp.weight_out);
                    check_field("prior_weight", oldest.prior, i_rsp.prior_weight);
                    check_field("mode_out", oldest.mode, i_rsp.mode_out);
                end
            end
            if (i_req.valid && i_req.ready) begin
                advance_animation(predicted);
                result_q.push_back(predicted);
            end
        end
        o_mismatches <= errors;
        o_pending    <= result_q.size();
        o_checked    <= compared;
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

// Drives the stepper with a directed opening and then randomised load and tick
// sequences over a series of register settings, with a bursty sender and a
// stalling receiver. The checker beside the block does all the comparing.
module tb_top;

    import aps_pkg::*;

    typedef logic signed [31:0] q16_t;

    localparam int   FRAC_BITS       = 16;
    localparam logic OP_TICK         = 1'b0;
    localparam logic OP_LOAD         = 1'b1;
    localparam q16_t Q_ONE           = 32'sh0001_0000;
    localparam q16_t Q_HALF          = 32'sh0000_8000;
    localparam logic [3:0] MODE_UNDEF = 4'd15;
    localparam logic [2:0] CFG_SPARE = 3'd7;
    localparam int   PHASES          = 13;
    localparam int   WORDS_PER_PHASE = 100;
    localparam int   PHASE_FLOOR     = 0;
    localparam int   PHASE_CEILING   = 1;
    localparam int   PHASE_SPARE     = 2;
    localparam int   SETTLE_CYCLES   = 16;
    localparam int   TAIL_CYCLES     = 32;
    localparam int   IDLE_LIMIT      = 4000;

    typedef struct {
        logic       op;
        q16_t       rate;
        q16_t       frame;
        q16_t       weight;
        logic [3:0] mode;
        q16_t       speed;
        q16_t       decay;
        q16_t       first;
        q16_t       last;
        q16_t       length;
        logic [7:0] kind;
    } anim_word_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_BURSTY
    } rx_style_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_idx;
    logic [31:0] i_cfg_wdata;

    int mismatches;
    int pending;
    int checked;
    int n_loads = 0;
    int n_ticks = 0;
    int n_settings = 1;
    int burst_left = 0;
    logic steady_sender = 1'b0;

    aps_in_if  req_if ();
    aps_out_if rsp_if ();

    animation_playback_stepper #(
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_req       (req_if),
        .o_rsp       (rsp_if)
    );

    aps_result_checker #(
        .FRAC_BITS (FRAC_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The receiver switches between stall patterns, each held for a random run.
    rx_style_t rx_style = RX_OPEN;
    int        rx_count = 0;

    always @(posedge i_clk) begin
        if (rx_count == 0) begin
            rx_style <= rx_style_t'($urandom_range(0, 3));
            rx_count <= $urandom_range(50, 300);
        end else begin
            rx_count <= rx_count - 1;
        end
        case (rx_style)
            RX_OPEN:   rsp_if.ready <= 1'b1;
            RX_COIN:   rsp_if.ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: rsp_if.ready <= ($urandom_range(0, 5) == 0);
            default:   rsp_if.ready <= rx_count[3];
        endcase
    end

    // Ends the run if neither channel moves a word for too long.
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles, %0d results outstanding",
                     $time, IDLE_LIMIT, pending);
            $display("Some tests failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Signed value of up to span whole frames with a random fraction.
    function automatic q16_t q_near(input int unsigned span);
        q16_t m;
        m = $urandom_range(0, span << FRAC_BITS);
        return $urandom_range(0, 1) ? -m : m;
    endfunction

    function automatic anim_word_t tick_word(input q16_t rate);
        anim_word_t w;
        w.op     = OP_TICK;
        w.rate   = rate;
        w.frame  = $urandom();
        w.weight = $urandom();
        w.mode   = 4'($urandom_range(0, 15));
        w.speed  = $urandom();
        w.decay  = $urandom();
        w.first  = $urandom();
        w.last   = $urandom();
        w.length = $urandom();
        w.kind   = 8'($urandom_range(0, 255));
        return w;
    endfunction

    function automatic anim_word_t load_word(input q16_t frame, input q16_t weight,
                                             input logic [3:0] mode, input q16_t speed,
                                             input q16_t decay, input q16_t first,
                                             input q16_t last, input q16_t length,
                                             input logic [7:0] kind);
        anim_word_t w;
        w        = tick_word($urandom());
        w.op     = OP_LOAD;
        w.frame  = frame;
        w.weight = weight;
        w.mode   = mode;
        w.speed  = speed;
        w.decay  = decay;
        w.first  = first;
        w.last   = last;
        w.length = length;
        w.kind   = kind;
        return w;
    endfunction

    // A load with a consistent loop: first below last, last no greater than the length.
    function automatic anim_word_t sensible_load();
        q16_t       first;
        q16_t       last;
        q16_t       length;
        q16_t       frame;
        q16_t       decay;
        logic [3:0] mode;
        logic [7:0] kind;
        first  = q_near(8);
        last   = first + Q_ONE + q16_t'($urandom_range(0, 32 << FRAC_BITS));
        length = last + q16_t'($urandom_range(0, 16 << FRAC_BITS));
        frame  = ($urandom_range(0, 4) == 0) ? last
                                             : first + q16_t'($urandom_range(0, last - first));
        decay  = ($urandom_range(0, 7) == 0) ? q_near(1)
                                             : q16_t'($urandom_range(0, Q_HALF));
        mode   = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                             : 4'($urandom_range(1, 8));
        kind   = $urandom_range(0, 1) ? 8'($urandom_range(0, 5)) : 8'($urandom_range(0, 255));
        return load_word(frame, $urandom_range(0, 2 << FRAC_BITS), mode, q_near(4), decay,
                         first, last, length, kind);
    endfunction

    function automatic q16_t pick_rate();
        case ($urandom_range(0, 19))
            0:       return -q16_t'($urandom_range(0, 4 << FRAC_BITS));
            1:       return $urandom_range(0, 1) ? Q_MIN : q16_t'(0);
            2:       return $urandom_range(0, 1) ? Q_MAX : q16_t'($urandom());
            default: return $urandom_range(1, 2 << FRAC_BITS);
        endcase
    endfunction

    // Offers one word, after a random gap when a burst has run out and the sender is not steady.
    task automatic send_word(input anim_word_t w);
        int gap;
        if (!steady_sender && burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = $urandom_range(1, 30);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        if (burst_left > 0) burst_left--;
        req_if.valid       <= 1'b1;
        req_if.operation   <= w.op;
        req_if.tick_rate   <= w.rate;
        req_if.load_frame  <= w.frame;
        req_if.load_weight <= w.weight;
        req_if.load_mode   <= w.mode;
        req_if.speed       <= w.speed;
        req_if.decay_rate  <= w.decay;
        req_if.first_frame <= w.first;
        req_if.last_frame  <= w.last;
        req_if.length      <= w.length;
        req_if.anim_kind   <= w.kind;
        do @(posedge i_clk); while (!req_if.ready);
        if (w.op == OP_LOAD) n_loads++;
        else n_ticks++;
    endtask

    task automatic tick(input q16_t rate);
        send_word(tick_word(rate));
    endtask

    // Holds the sender until every predicted result word has been taken.
    task automatic drain();
        req_if.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= data;
        @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_scale();
        logic [31:0] s;
        case ($urandom_range(0, 7))
            0:       s = $urandom();
            1:       s = '0;
            default: s = $urandom_range(32'h2000, 32'h3_0000);
        endcase
        // The top bit lies outside the register and must be dropped.
        return $urandom_range(0, 1) ? (s | 32'h8000_0000) : (s & 32'h7FFF_FFFF);
    endfunction

    function automatic logic [31:0] pick_level();
        case ($urandom_range(0, 7))
            0:       return $urandom();
            1:       return '0;
            default: return q_near(2);
        endcase
    endfunction

    // Writes all five registers; the first two settings and the last are fixed.
    task automatic apply_setting(input int phase);
        logic [31:0] scale[3];
        logic [31:0] level[2];
        if (phase == PHASE_FLOOR) begin
            scale = '{3{32'h0}};
            level = '{2{Q_MIN}};
        end else if (phase == PHASE_CEILING) begin
            scale = '{3{32'hFFFF_FFFF}};
            level = '{2{Q_MAX}};
        end else if (phase == PHASES - 1) begin
            scale = '{3{Q_ONE}};
            level = '{2{32'h0}};
        end else begin
            scale = '{pick_scale(), pick_scale(), pick_scale()};
            level = '{pick_level(), pick_level()};
        end
        write_reg(CFG_LEGACY_SCALE, scale[0]);
        write_reg(CFG_DIRECT_SCALE, scale[1]);
        write_reg(CFG_TAPER_SCALE, scale[2]);
        write_reg(CFG_ZERO_LEVEL, level[0]);
        write_reg(CFG_TAPER_ZERO, level[1]);
        if (phase == PHASE_SPARE) write_reg(CFG_SPARE, $urandom());
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // Mostly a load followed by a run of ticks, with noise pairs of a random load and a tick between.
    task automatic run_random(input int count);
        int sent;
        int run_len;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 3) == 0) begin
                send_word(load_word($urandom(), $urandom(), 4'($urandom_range(0, 15)),
                                    $urandom(), $urandom(), $urandom(), $urandom(),
                                    $urandom(), 8'($urandom_range(0, 255))));
                send_word(tick_word($urandom()));
                sent += 2;
            end else begin
                send_word(sensible_load());
                run_len = $urandom_range(1, 12);
                repeat (run_len) tick(pick_rate());
                sent += 1 + run_len;
            end
        end
    endtask

    initial begin
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_idx          <= '0;
        i_cfg_wdata        <= '0;
        req_if.valid       <= 1'b0;
        req_if.operation   <= OP_TICK;
        req_if.tick_rate   <= '0;
        req_if.load_frame  <= '0;
        req_if.load_weight <= '0;
        req_if.load_mode   <= MODE_IDLE;
        req_if.speed       <= '0;
        req_if.decay_rate  <= '0;
        req_if.first_frame <= '0;
        req_if.last_frame  <= '0;
        req_if.length      <= '0;
        req_if.anim_kind   <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Ticks straight after reset, in idle mode and with bad rates.
        tick(Q_ONE);
        tick('0);
        tick(Q_MIN);

        // Loop wrapping forwards, saturation on a huge rate, and backwards.
        send_word(load_word(32'sh0009_8000, '0, MODE_LEGACY_LOOP, Q_ONE, '0, '0, '0,
                            32'sh000A_0000, 8'd0));
        tick(Q_ONE);
        tick(Q_MAX);
        send_word(load_word('0, '0, MODE_DIRECT_LOOP, -Q_ONE, '0, '0, '0,
                            32'sh000A_0000, 8'd0));
        tick(Q_HALF);

        // Play once overshooting the end, then the completion on the next tick.
        send_word(load_word(32'sh0008_0000, '0, MODE_LEGACY_ONCE, 32'sh0004_0000, '0, '0,
                            32'sh000A_0000, 32'sh0014_0000, 8'd0));
        tick(Q_ONE);
        tick(Q_ONE);
        send_word(load_word(32'sh0005_0000, '0, MODE_DIRECT_ONCE, Q_ONE, '0, '0,
                            32'sh0005_0000, 32'sh0014_0000, 8'd0));
        tick(Q_ONE);

        // Partial loop falling below its start frame.
        send_word(load_word(32'sh0002_8000, '0, MODE_DIRECT_PART, -Q_ONE, '0,
                            32'sh0002_0000, 32'sh0006_0000, 32'sh0014_0000, 8'd0));
        tick(Q_ONE);

        // Morph decay, reaching the floor in all but the second case, with several follow-on modes.
        send_word(load_word('0, Q_HALF, MODE_LEGACY_MORPH, '0, Q_ONE, '0, '0, '0, 8'd0));
        tick(Q_ONE);
        send_word(load_word('0, 32'sh0002_0000, MODE_LEGACY_MORPH, '0, 32'sh0000_4000,
                            '0, '0, '0, 8'd7));
        tick(Q_ONE);
        send_word(load_word('0, Q_HALF, MODE_DIRECT_MORPH, '0, Q_ONE, '0, '0, '0, 8'd255));
        tick(Q_ONE);
        send_word(load_word('0, Q_ONE, MODE_TAPER_MORPH, '0, 32'sh0002_0000, '0, '0, '0,
                            8'd2));
        tick(Q_ONE);

        // Undefined mode, then every held value at its extreme.
        send_word(load_word(Q_MAX, Q_MIN, MODE_UNDEF, Q_MIN, Q_MAX, Q_MAX, Q_MIN, Q_MAX,
                            8'd255));
        tick(Q_ONE);
        send_word(load_word(Q_MIN, Q_MAX, MODE_LEGACY_LOOP, Q_MAX, Q_MIN, Q_MIN, Q_MAX,
                            Q_MIN, 8'd0));
        tick(Q_MAX);

        for (int phase = 0; phase < PHASES; phase++) begin
            drain();
            repeat (SETTLE_CYCLES) @(posedge i_clk);
            apply_setting(phase);
            steady_sender = (phase % 4 == 3);
            run_random(WORDS_PER_PHASE);
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Sent %0d load and %0d tick words under %0d register settings.",
                 n_loads, n_ticks, n_settings);
        $display("Compared %0d result words, %0d mismatching fields.", checked, mismatches);
        if (mismatches == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
